[src/cssk_pkg.sv]
// Shared constants, types and register codes of the cubic spline SPH kernel unit.
`default_nettype none

package cssk_pkg;

	localparam int PIPE_DEPTH   = 8;   // total register stages, input to output
	localparam int SHAPE_STAGES = 4;   // stages in the shape part, rest in the scale part

	localparam int VEC_DIM_DEF = 3;

	localparam logic [31:0] ONE_Q16        = 32'h0001_0000;
	localparam logic [31:0] DEF_FACTOR_3D  = 32'd20861;   // 1/pi
	localparam logic [31:0] DEF_FACTOR_2D  = 32'd29801;   // 10/(7 pi)

	localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	typedef enum logic [1:0] {
		REG_INV_LEN      = 2'd0,
		REG_VALUE_FACTOR = 2'd1,
		REG_GRAD_FACTOR  = 2'd2
	} reg_idx_t;

	// stage load enables, bit 0 is the first stage
	typedef struct packed {
		logic [PIPE_DEPTH-1:0] en;
	} pipe_ctl_t;

	// distance vector in sign and magnitude form
	typedef struct packed {
		logic [2:0]       neg;
		logic [2:0][31:0] mag;
	} vec_sm_t;

	function automatic logic [31:0] def_factor(input int dim);
		logic [31:0] f;
		f = (dim == 2) ? DEF_FACTOR_2D : DEF_FACTOR_3D;
		return f;
	endfunction

endpackage

`default_nettype wire

[src/cssk_ifs.sv]
// Valid/ready channel interfaces for pair inputs and kernel results.
`default_nettype none

interface cssk_in_if;
	logic               valid;
	logic               ready;
	logic        [31:0] pair_distance;
	logic signed [31:0] delta_x;
	logic signed [31:0] delta_y;
	logic signed [31:0] delta_z;

	modport source(output valid, pair_distance, delta_x, delta_y, delta_z, input ready);
	modport sink(input valid, pair_distance, delta_x, delta_y, delta_z, output ready);
endinterface

interface cssk_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] kernel_value;
	logic signed [31:0] grad_x;
	logic signed [31:0] grad_y;
	logic signed [31:0] grad_z;

	modport source(output valid, kernel_value, grad_x, grad_y, grad_z, input ready);
	modport sink(input valid, kernel_value, grad_x, grad_y, grad_z, output ready);
endinterface

`default_nettype wire

[src/cssk_pipe_ctrl.sv]
// Valid bits and per-stage load enables of the kernel pipeline.
`default_nettype none

module cssk_pipe_ctrl
	import cssk_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	output pipe_ctl_t      ctl
);

	logic [PIPE_DEPTH-1:0] v_q;
	logic [PIPE_DEPTH-1:0] en;

	// a stage loads when empty or when its contents move on
	always_comb begin
		en[PIPE_DEPTH-1] = ~v_q[PIPE_DEPTH-1] | out_ready;
		for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
			en[k] = ~v_q[k] | en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < PIPE_DEPTH; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign ctl.en    = en;
	assign in_ready  = en[0];
	assign out_valid = v_q[PIPE_DEPTH-1];

	// back-pressure at the input only when every stage holds a beat
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&v_q && !out_ready))
		else $error("input blocked while pipeline has a bubble");

	// an accepted beat lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_q[0])
		else $error("accepted beat lost at pipeline entry");

	// a taken result with nothing behind it empties the output stage
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[PIPE_DEPTH-1] && out_ready && !v_q[PIPE_DEPTH-2]) |=> !v_q[PIPE_DEPTH-1])
		else $error("result repeated after it was taken");

	// a stalled result stays in place
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[PIPE_DEPTH-1] && !out_ready) |=> v_q[PIPE_DEPTH-1])
		else $error("stalled result dropped");

endmodule

`default_nettype wire

[src/cssk_shape.sv]
// Stages 1-4: q = distance * inverse length, region decode, spline shape f and |g|.
`default_nettype none

module cssk_shape
	import cssk_pkg::*;
(
	input  wire logic        clk,
	input  wire pipe_ctl_t   ctl,
	input  wire logic [31:0] inv_len,
	input  wire logic [31:0] pair_distance,
	input  wire logic [31:0] delta_x,
	input  wire logic [31:0] delta_y,
	input  wire logic [31:0] delta_z,
	output logic      [32:0] f32,
	output logic      [32:0] g32,
	output vec_sm_t          vec
);

	// stage 1
	logic [63:0] q_prod;
	logic [47:0] q_s1;
	vec_sm_t     vec_in;
	vec_sm_t     vec_s1;

	// stage 2
	logic        lo_c;
	logic        sup_c;
	logic [17:0] b_c;
	logic [16:0] u_c;
	logic [16:0] u_s2;
	logic [33:0] u2_s2;
	logic        lo_s2;
	logic        sup_s2;
	vec_sm_t     vec_s2;

	// stage 3
	logic [50:0] u3_s3;
	logic [33:0] u2_s3;
	logic [16:0] u_s3;
	logic        lo_s3;
	logic        sup_s3;
	vec_sm_t     vec_s3;

	// stage 4
	logic [52:0] t3_c;
	logic [35:0] u2x3_c;
	logic [52:0] f50_c;
	logic [18:0] ux3_c;
	logic [37:0] g34_c;
	logic [52:0] f_rnd_c;
	logic [37:0] g_rnd_c;
	logic [32:0] f32_s4;
	logic [32:0] g32_s4;
	vec_sm_t     vec_s4;

	always_comb begin
		vec_in.neg = {delta_z[31], delta_y[31], delta_x[31]};
		vec_in.mag[0] = delta_x[31] ? (~delta_x + 32'd1) : delta_x;
		vec_in.mag[1] = delta_y[31] ? (~delta_y + 32'd1) : delta_y;
		vec_in.mag[2] = delta_z[31] ? (~delta_z + 32'd1) : delta_z;
	end

	assign q_prod = {32'd0, pair_distance} * {32'd0, inv_len};

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			q_s1   <= q_prod[63:16];
			vec_s1 <= vec_in;
		end
	end

	// inner region uses q, outer region uses 2 - q
	always_comb begin
		lo_c  = (q_s1[47:16] == 32'd0);
		sup_c = (q_s1[47:17] == 31'd0);
		b_c   = 18'h2_0000 - {1'b0, q_s1[16:0]};
		u_c   = lo_c ? q_s1[16:0] : b_c[16:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			u_s2   <= u_c;
			u2_s2  <= {17'd0, u_c} * {17'd0, u_c};
			lo_s2  <= lo_c;
			sup_s2 <= sup_c;
			vec_s2 <= vec_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			u3_s3  <= {17'd0, u2_s2} * {34'd0, u_s2};
			u2_s3  <= u2_s2;
			u_s3   <= u_s2;
			lo_s3  <= lo_s2;
			sup_s3 <= sup_s2;
			vec_s3 <= vec_s2;
		end
	end

	// f in Q.50 and |g| in Q.34, then round half up to Q.32
	always_comb begin
		t3_c   = {2'b00, u3_s3} + {1'b0, u3_s3, 1'b0};
		u2x3_c = {2'b00, u2_s3} + {1'b0, u2_s3, 1'b0};
		ux3_c  = {2'b00, u_s3} + {1'b0, u_s3, 1'b0};
		if (lo_s3) begin
			f50_c = (53'd1 << 50) + t3_c - {u2x3_c, 17'd0};
			g34_c = {1'b0, ux3_c, 18'd0} - ({1'b0, u2_s3, 3'd0} + {4'd0, u2_s3});
		end else begin
			f50_c = {2'b00, u3_s3};
			g34_c = {2'b00, u2x3_c};
		end
		f_rnd_c = f50_c + 53'h2_0000;
		g_rnd_c = g34_c + 38'd2;
	end

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			f32_s4 <= sup_s3 ? f_rnd_c[50:18] : 33'd0;
			g32_s4 <= sup_s3 ? g_rnd_c[34:2] : 33'd0;
			vec_s4 <= vec_s3;
		end
	end

	assign f32 = f32_s4;
	assign g32 = g32_s4;
	assign vec = vec_s4;

endmodule

`default_nettype wire

[src/cssk_scale.sv]
// Stages 5-8: factor products, gradient scale, vector products, rounding and saturation.
`default_nettype none

module cssk_scale
	import cssk_pkg::*;
#(
	parameter int VEC_DIM = VEC_DIM_DEF
)
(
	input  wire logic        clk,
	input  wire pipe_ctl_t   ctl,
	input  wire logic [31:0] value_factor,
	input  wire logic [31:0] grad_factor,
	input  wire logic [32:0] f32,
	input  wire logic [32:0] g32,
	input  wire vec_sm_t     vec,
	output logic      [31:0] kernel_value,
	output logic      [31:0] grad_x,
	output logic      [31:0] grad_y,
	output logic      [31:0] grad_z
);

	logic [64:0]       pk_s5;
	logic [64:0]       pg_s5;
	vec_sm_t           vec_s5;

	logic [65:0]       k_rnd_c;
	logic [65:0]       g_rnd_c;
	logic [31:0]       kv_s6;
	logic [32:0]       s_s6;
	vec_sm_t           vec_s6;

	logic [31:0]       kv_s7;
	logic [2:0][64:0]  pc_s7;
	logic [2:0]        neg_s7;

	logic [2:0][65:0]  c_rnd_c;
	logic [2:0][49:0]  r_c;
	logic [2:0][31:0]  c_c;
	logic [31:0]       kv_s8;
	logic [2:0][31:0]  c_s8;

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			pk_s5  <= {33'd0, value_factor} * {32'd0, f32};
			pg_s5  <= {33'd0, grad_factor} * {32'd0, g32};
			vec_s5 <= vec;
		end
	end

	assign k_rnd_c = {1'b0, pk_s5} + 66'h8000_0000;
	assign g_rnd_c = {1'b0, pg_s5} + 66'h8000_0000;

	// kernel value is bits 63:32 of the rounded product; saturate above 2^31 - 1
	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			kv_s6  <= (k_rnd_c[65:63] != 3'd0) ? SAT_MAX : k_rnd_c[63:32];
			s_s6   <= g_rnd_c[64:32];
			vec_s6 <= vec_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[6]) begin
			kv_s7  <= kv_s6;
			neg_s7 <= vec_s6.neg;
			for (int i = 0; i < 3; i++) begin
				pc_s7[i] <= {32'd0, s_s6} * {33'd0, vec_s6.mag[i]};
			end
		end
	end

	// gradient points against the vector: negative delta gives a positive result
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c_rnd_c[i] = {1'b0, pc_s7[i]} + 66'h8000;
			r_c[i]     = c_rnd_c[i][65:16];
			if (neg_s7[i]) begin
				c_c[i] = (r_c[i] > {18'd0, SAT_MAX}) ? SAT_MAX : r_c[i][31:0];
			end else begin
				c_c[i] = (r_c[i] > {18'd0, SAT_MIN}) ? SAT_MIN : (~r_c[i][31:0] + 32'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[7]) begin
			kv_s8 <= kv_s7;
			c_s8  <= c_c;
		end
	end

	assign kernel_value = kv_s8;
	assign grad_x       = c_s8[0];
	assign grad_y       = c_s8[1];
	assign grad_z       = (VEC_DIM == 2) ? 32'd0 : c_s8[2];

endmodule

`default_nettype wire

[src/cubic_spline_sph_kernel_unit.sv]
// Top level of the cubic spline SPH kernel unit: registers, pipeline control, datapath.
//
//  channel  dir  payload                                   beat taken when
//  in_ch    in   pair_distance, delta_x, delta_y, delta_z  valid & ready
//  out_ch   out  kernel_value, grad_x, grad_y, grad_z      valid & ready
//  cfg      in   cfg_index, cfg_wdata                      cfg_we
//
// Eight register stages; one beat in and one result out per cycle while out_ch.ready is high.
// Stage 8 is the output register; ready runs back stage by stage, so bubbles close
// up behind a stalled result and input is refused only when all 8 stages are full.
// arst_n clears the valid bits and loads the register defaults (inverse length 1.0,
// factors per VEC_DIM); datapath registers are not reset.
`default_nettype none

module cubic_spline_sph_kernel_unit
	import cssk_pkg::*;
#(
	parameter int VEC_DIM = VEC_DIM_DEF
)
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	cssk_in_if.sink          in_ch,
	cssk_out_if.source       out_ch
);

	// configuration registers; the user must write them only while the pipeline is empty, the block does not enforce it
	logic [31:0] inv_len_q;
	logic [31:0] value_factor_q;
	logic [31:0] grad_factor_q;

	pipe_ctl_t   ctl;
	logic [32:0] f32;
	logic [32:0] g32;
	vec_sm_t     vec;
	logic [31:0] kernel_value;
	logic [31:0] grad_x;
	logic [31:0] grad_y;
	logic [31:0] grad_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_len_q      <= ONE_Q16;
			value_factor_q <= def_factor(VEC_DIM);
			grad_factor_q  <= def_factor(VEC_DIM);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INV_LEN:      inv_len_q      <= cfg_wdata;
				REG_VALUE_FACTOR: value_factor_q <= cfg_wdata;
				REG_GRAD_FACTOR:  grad_factor_q  <= cfg_wdata;
				default: ;    // unused index, write dropped
			endcase
		end
	end

	// valid bits and stage enables
	cssk_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.ctl       (ctl)
	);

	// stages 1-4: q, region, u^2, u^3, f and |g| rounded to Q.32
	cssk_shape u_shape (
		.clk           (clk),
		.ctl           (ctl),
		.inv_len       (inv_len_q),
		.pair_distance (in_ch.pair_distance),
		.delta_x       (in_ch.delta_x),
		.delta_y       (in_ch.delta_y),
		.delta_z       (in_ch.delta_z),
		.f32           (f32),
		.g32           (g32),
		.vec           (vec)
	);

	// stages 5-8: times factors, gradient scale times vector, saturate
	cssk_scale #(
		.VEC_DIM (VEC_DIM)
	) u_scale (
		.clk          (clk),
		.ctl          (ctl),
		.value_factor (value_factor_q),
		.grad_factor  (grad_factor_q),
		.f32          (f32),
		.g32          (g32),
		.vec          (vec),
		.kernel_value (kernel_value),
		.grad_x       (grad_x),
		.grad_y       (grad_y),
		.grad_z       (grad_z)
	);

	assign out_ch.kernel_value = kernel_value;
	assign out_ch.grad_x       = grad_x;
	assign out_ch.grad_y       = grad_y;
	assign out_ch.grad_z       = grad_z;

endmodule

`default_nettype wire

[verif/cubic_spline_sph_kernel_unit_test.sv]
// Self-checking testbench of the cubic spline SPH kernel unit: random pair beats, checked results.
`default_nettype none

module cubic_spline_sph_kernel_unit_test;
	import cssk_pkg::*;

	localparam int VEC_DIM = VEC_DIM_DEF;

	// no register answers at this index, so writes there must change nothing
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// q thresholds of the three kernel regions, unsigned Q.16
	localparam logic [63:0] Q_ONE = 64'h0_0001_0000;
	localparam logic [63:0] Q_TWO = 64'h0_0002_0000;

	localparam int NUM_PHASES      = 9;
	localparam int ITEMS_PER_PHASE = 220;
	localparam int LONG_HOLD       = 40;   // well beyond PIPE_DEPTH, so the input backs up
	localparam int MAX_REPORTS     = 10;
	localparam int TIMEOUT         = 3_000_000;

	typedef struct packed {
		logic [31:0] pair_distance;
		logic [31:0] delta_x;
		logic [31:0] delta_y;
		logic [31:0] delta_z;
	} pair_t;

	typedef struct packed {
		logic [31:0] kernel_value;
		logic [31:0] grad_x;
		logic [31:0] grad_y;
		logic [31:0] grad_z;
	} kernel_res_t;

	// Holds a copy of the three registers and the kernel results still owed by the block.
	class sph_kernel_board;
		logic [31:0] inv_len;
		logic [31:0] val_fac;
		logic [31:0] grad_fac;
		int          vec_dim;
		kernel_res_t owed_results[$];
		int          mismatches;

		static string field_names[4] = '{"kernel_value", "grad_x", "grad_y", "grad_z"};

		function new(int dim);
			vec_dim    = dim;
			inv_len    = ONE_Q16;
			val_fac    = (dim == 2) ? DEF_FACTOR_2D : DEF_FACTOR_3D;
			grad_fac   = val_fac;
			mismatches = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_INV_LEN:      inv_len  = val;
				REG_VALUE_FACTOR: val_fac  = val;
				REG_GRAD_FACTOR:  grad_fac = val;
				default:          ;
			endcase
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		function logic [31:0] clamp_pos(logic [63:0] v);
			return (v > 64'h7FFF_FFFF) ? SAT_MAX : v[31:0];
		endfunction

		// -(s * d) rounded half away from zero, saturated
		function logic [31:0] scale_axis(logic [63:0] s, logic [31:0] d);
			logic [31:0] mag;
			logic [63:0] r;
			mag = d[31] ? (~d + 32'd1) : d;
			r = (s * {32'b0, mag} + 64'h8000) >> 16;
			if (d[31])
				return clamp_pos(r);
			if (r > 64'h8000_0000)
				return SAT_MIN;
			return ~r[31:0] + 32'd1;
		endfunction

		function kernel_res_t eval_kernel(pair_t p);
			logic [63:0] q, q2, q3, b, f50, g34, f32, g32, kv, s;
			bit          grad_on;
			kernel_res_t r;
			q = ({32'b0, p.pair_distance} * {32'b0, inv_len}) >> 16;
			f50 = 64'd0;
			g34 = 64'd0;
			grad_on = 1'b0;
			if (q < Q_ONE) begin
				q2 = q * q;
				q3 = q2 * q;
				f50 = (64'd1 << 50) + 64'd3 * q3 - ((64'd3 * q2) << 17);
				if (q != 64'd0) begin
					g34 = ((64'd3 * q) << 18) - 64'd9 * q2;
					grad_on = 1'b1;
				end
			end else if (q < Q_TWO) begin
				b = Q_TWO - q;
				f50 = b * b * b;
				g34 = 64'd3 * b * b;
				grad_on = 1'b1;
			end
			f32 = (f50 + (64'd1 << 17)) >> 18;
			kv = ({32'b0, val_fac} * f32 + 64'h8000_0000) >> 32;
			r = '0;
			r.kernel_value = clamp_pos(kv);
			if (grad_on) begin
				g32 = (g34 + 64'd2) >> 2;
				s = ({32'b0, grad_fac} * g32 + 64'h8000_0000) >> 32;
				r.grad_x = scale_axis(s, p.delta_x);
				r.grad_y = scale_axis(s, p.delta_y);
				r.grad_z = (vec_dim == 2) ? 32'd0 : scale_axis(s, p.delta_z);
			end
			return r;
		endfunction

		function void note_pair(pair_t p);
			owed_results.push_back(eval_kernel(p));
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch: %s", msg);
		endfunction

		function void check_result(kernel_res_t got);
			kernel_res_t want;
			logic [31:0] w[4];
			logic [31:0] g[4];
			if (owed_results.size() == 0) begin
				flag($sformatf("result beat with nothing owed, kernel_value %h", got.kernel_value));
				return;
			end
			want = owed_results.pop_front();
			w = '{want.kernel_value, want.grad_x, want.grad_y, want.grad_z};
			g = '{got.kernel_value, got.grad_x, got.grad_y, got.grad_z};
			for (int i = 0; i < 4; i++) begin
				if (g[i] !== w[i])
					flag($sformatf("%s expected %h actual %h", field_names[i], w[i], g[i]));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_wdata;

	cssk_in_if  in_ch();
	cssk_out_if out_ch();

	sph_kernel_board board = new(VEC_DIM);

	// idling switches, flipped by the stimulus process per phase
	bit src_idle_en   = 1'b1;
	bit sink_idle_en  = 1'b1;
	bit long_hold_req = 1'b0;

	logic [31:0] cur_inv;   // inverse length in force, used to aim distances at the regions

	pair_t corner_pairs[10];

	cubic_spline_sph_kernel_unit #(
		.VEC_DIM(VEC_DIM)
	) i_dut (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_wdata,
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #5 clk = ~clk;

	// Every result beat goes to the board; values are sampled before this
	// edge's updates land, so they are the ones the handshake took.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			board.check_result({out_ch.kernel_value, out_ch.grad_x, out_ch.grad_y,
				out_ch.grad_z});
	end

	// Result side: short random stalls, plus one long hold-off on request
	// so the eight stages fill and the input side gets refused.
	initial begin : sink_ready
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
				out_ch.ready <= 1'b1;
			end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Sets up one register write, takes the edge it lands on and updates the copy.
	// Leaves cfg_we high so back-to-back writes never drop it in between.
	task automatic poke_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		board.write_reg(idx, val);
	endtask

	// Only called with the pipe empty. The unused index gets junk too.
	task automatic program_regs(input logic [31:0] inv, input logic [31:0] vf,
		input logic [31:0] gf);
		poke_reg(REG_INV_LEN, inv);
		poke_reg(REG_VALUE_FACTOR, vf);
		poke_reg(REG_GRAD_FACTOR, gf);
		poke_reg(REG_UNUSED, $urandom());
		cfg_we <= 1'b0;
		cur_inv = inv;
	endtask

	// Offers one pair, maybe after a short gap, and returns at the edge it was taken.
	// valid stays high on return so the next beat can follow at once.
	task automatic send_pair(input pair_t p);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.pair_distance <= p.pair_distance;
		in_ch.delta_x       <= p.delta_x;
		in_ch.delta_y       <= p.delta_y;
		in_ch.delta_z       <= p.delta_z;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		board.note_pair(p);
	endtask

	task automatic drain();
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// Aims q at the interesting spots: mostly spread over [0, 2.25], some right at
	// the region edges, the rest raw 32-bit distances that land mostly far outside.
	function automatic logic [31:0] pick_distance(logic [31:0] inv);
		logic [63:0] tq;
		logic [63:0] d;
		case ($urandom_range(0, 9))
			0, 1: return $urandom();
			2: begin
				case ($urandom_range(0, 5))
					0:       tq = 64'd0;
					1:       tq = 64'd1;
					2:       tq = Q_ONE - 64'd1;
					3:       tq = Q_ONE;
					4:       tq = Q_TWO - 64'd1;
					default: tq = Q_TWO;
				endcase
			end
			default: tq = $urandom_range(0, 32'h0002_4000);
		endcase
		if (inv == 32'd0)
			return $urandom();
		// ceiling so that the truncated q starts at the target
		d = ((tq << 16) + {32'b0, inv} - 64'd1) / {32'b0, inv};
		return (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
	endfunction

	function automatic logic [31:0] pick_delta();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0:       return 32'h8000_0000;
					1:       return 32'h7FFF_FFFF;
					2:       return 32'h0000_0000;
					3:       return 32'hFFFF_FFFF;
					default: return 32'h0000_0001;
				endcase
			end
			1, 2, 3: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] pick_factor();
		return ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 32'h0004_0000);
	endfunction

	initial begin : stimulus
		pair_t       p;
		logic [31:0] inv;
		logic [31:0] vf;
		logic [31:0] gf;

		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= REG_INV_LEN;
		cfg_wdata           <= '0;
		in_ch.valid         <= 1'b0;
		in_ch.pair_distance <= '0;
		in_ch.delta_x       <= '0;
		in_ch.delta_y       <= '0;
		in_ch.delta_z       <= '0;
		cur_inv = ONE_Q16;

		// with inverse length 1.0 the distance is q itself
		corner_pairs = '{
			'{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001},  // zero q
			'{32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF},  // smallest q
			'{32'h0000_8000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000},  // q = 0.5
			'{32'h0000_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_2345},  // just below 1
			'{32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000},  // q = 1
			'{32'h0001_8000, 32'h0002_0000, 32'hFFFE_0000, 32'h7FFF_FFFF},  // q = 1.5
			'{32'h0001_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000},  // just below 2
			'{32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF},  // edge of support
			'{32'hFFFF_FFFF, 32'h1234_5678, 32'h8765_4321, 32'h0000_0001},  // far outside
			'{32'h0000_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'hCCCC_CCCC}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners first on reset defaults, then again with both factors at
		// full scale so kernel and gradient saturate
		foreach (corner_pairs[i])
			send_pair(corner_pairs[i]);
		in_ch.valid <= 1'b0;
		drain();
		program_regs(ONE_Q16, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		foreach (corner_pairs[i])
			send_pair(corner_pairs[i]);
		in_ch.valid <= 1'b0;
		drain();

		// Random phases. The first three pin the register extremes: zero inverse
		// length (q always zero), everything at all ones, factors at zero.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin
					inv = 32'd0;
					vf  = pick_factor();
					gf  = pick_factor();
				end
				1: begin
					inv = 32'hFFFF_FFFF;
					vf  = 32'hFFFF_FFFF;
					gf  = 32'hFFFF_FFFF;
				end
				2: begin
					inv = ONE_Q16;
					vf  = 32'd0;
					gf  = 32'd0;
				end
				default: begin
					inv = $urandom_range(32'h0000_2000, 32'h0008_0000);
					vf  = pick_factor();
					gf  = pick_factor();
				end
			endcase
			program_regs(inv, vf, gf);

			// no gaps while the result side holds off; last phase runs flat out
			src_idle_en  = (phase != 3) && (phase != NUM_PHASES - 1);
			sink_idle_en = (phase != NUM_PHASES - 1);

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == 3 && n == 40)
					long_hold_req = 1'b1;
				if (phase == 4 && n == 100) begin
					// sender waits for the pipe to run dry mid-phase
					in_ch.valid <= 1'b0;
					drain();
				end
				p.pair_distance = pick_distance(cur_inv);
				p.delta_x       = pick_delta();
				p.delta_y       = pick_delta();
				p.delta_z       = pick_delta();
				send_pair(p);
			end
			in_ch.valid <= 1'b0;
			drain();
		end

		// let any stray beats show up before the verdict
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
src/cssk_pkg.sv
src/cssk_ifs.sv
src/cssk_pipe_ctrl.sv
src/cssk_shape.sv
src/cssk_scale.sv
src/cubic_spline_sph_kernel_unit.sv
verif/cubic_spline_sph_kernel_unit_test.sv
